### rtl/core/lfpd_pkg.sv
// Shared types and constants of the line-follow PD controller.
// Used by the controller, the datapath and the top level; no dependencies.

package lfpd_pkg;

    // Register widths
    localparam int LINE_W  = 10;
    localparam int TIME_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int MAXC_W  = 7;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 3;
    localparam int CORR_W  = 8;
    // Widest sample the bounds are widened to before trimming
    localparam int EXT_W   = 16;

    // Register indexes
    localparam logic [CIDX_W-1:0] CFG_LINE_LOW  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_LINE_HIGH = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_STALE     = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_P_GAIN    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_D_GAIN    = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_MAX_CORR  = 3'd5;

    // Register file contents
    typedef struct packed {
        logic [LINE_W-1:0] line_low;
        logic [LINE_W-1:0] line_high;
        logic [TIME_W-1:0] stale_time_us;
        logic [GAIN_W-1:0] p_gain_q16;
        logic [GAIN_W-1:0] d_gain;
        logic [MAXC_W-1:0] max_correction;
    } cfg_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic mul;
        logic div_load;
        logic div_step;
        logic fix;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_blocked;
    } status_t;

endpackage

### rtl/core/lfpd_ctrl.sv
// Sequencer of the line-follow PD controller: walks one transaction through
// prepare, multiply, divide and finish. Depends on lfpd_pkg.

module lfpd_ctrl
    import lfpd_pkg::*;
#(
    parameter int DIV_STEPS = 42
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIX  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = CNT_W'(DIV_STEPS - 1);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold while the previous result is still waiting
                if (!status.out_blocked)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/core/lfpd_dp.sv
// Datapath of the line-follow PD controller: staleness check, clamp, P and D
// products, restoring divider for the D term, sum, saturation and output register.
// Depends on lfpd_pkg.

module lfpd_dp
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  cmd_t                     cmd,
    output status_t                  status,
    input  logic [SAMPLE_BITS-1:0]   sensor_reading,
    input  logic [TIME_W-1:0]        timestamp_us,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [CORR_W-1:0] correction_left,
    output logic signed [CORR_W-1:0] correction_right
);

    localparam int S    = SAMPLE_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DW   = S + 1;              // signed sample difference
    localparam int PPW  = GAIN_W + 1 + DW;    // signed P product
    localparam int MAGW = GAIN_W + S;         // D product magnitude
    localparam int MW   = MAGW + F;           // dividend / quotient
    localparam int DTW  = MW + 2;             // signed D term
    localparam int SW   = PPW + F + 1;        // signed sum
    localparam int CW   = SW - F;             // integer part of sum

    // Input capture and stored state
    logic [S-1:0]      raw_reg;
    logic [TIME_W-1:0] ts_reg;
    logic [S-1:0]      prev_sample_reg;
    logic [TIME_W-1:0] prev_time_reg;

    // Prepare stage
    logic [TIME_W-1:0] elapsed_reg;
    logic [S-1:0]      base_reg;
    logic [S-1:0]      v_reg;
    logic [S-1:0]      mid_reg;

    // Multiply stage
    logic signed [PPW-1:0] pprod_reg;
    logic [MAGW-1:0]       dmag_reg;
    logic                  dneg_reg;

    // Divider
    logic [MW-1:0]     q_reg;
    logic [TIME_W-1:0] rem_reg;

    logic signed [DTW-1:0] dterm_reg;

    logic                     out_valid_reg;
    logic signed [CORR_W-1:0] left_reg;
    logic signed [CORR_W-1:0] right_reg;

    // Bounds trimmed to the sample width
    logic [EXT_W-1:0]  lo_ext, hi_ext;
    logic [S-1:0]      lo, hi;
    logic [TIME_W-1:0] elapsed_now;
    logic              refresh;
    logic [S-1:0]      v_lo, v_now;
    logic [S:0]        mid_sum;

    assign lo_ext  = EXT_W'(cfg.line_low);
    assign hi_ext  = EXT_W'(cfg.line_high);
    assign lo      = lo_ext[S-1:0];
    assign hi      = hi_ext[S-1:0];

    // Elapsed time and stale check; lower clamp before upper
    assign elapsed_now = ts_reg - prev_time_reg;
    assign refresh     = (prev_time_reg == '0) || (elapsed_now > cfg.stale_time_us);
    assign v_lo        = (raw_reg < lo) ? lo : raw_reg;
    assign v_now       = (v_lo > hi) ? hi : v_lo;
    assign mid_sum     = {1'b0, lo} + {1'b0, hi};

    // Differences and products
    logic signed [DW-1:0]  p_diff, d_diff, d_abs_s;
    logic [S-1:0]          d_abs;
    logic signed [PPW-1:0] pprod_now;
    logic [MAGW-1:0]       dmag_now;

    assign p_diff    = $signed({1'b0, v_reg}) - $signed({1'b0, mid_reg});
    assign d_diff    = $signed({1'b0, v_reg}) - $signed({1'b0, base_reg});
    assign d_abs_s   = d_diff[DW-1] ? -d_diff : d_diff;
    assign d_abs     = d_abs_s[S-1:0];
    assign pprod_now = $signed({1'b0, cfg.p_gain_q16}) * p_diff;
    assign dmag_now  = cfg.d_gain * d_abs;

    // One quotient bit per step
    logic [TIME_W:0]   div_shift, div_sub;
    logic              div_ge;
    logic [TIME_W-1:0] rem_step;

    assign div_shift = {rem_reg, q_reg[MW-1]};
    assign div_sub   = div_shift - {1'b0, elapsed_reg};
    assign div_ge    = div_shift >= {1'b0, elapsed_reg};
    assign rem_step  = div_ge ? div_sub[TIME_W-1:0] : div_shift[TIME_W-1:0];

    // Floor of the signed quotient
    logic [MW:0]           q_ceil;
    logic signed [DTW-1:0] dterm_now;

    assign q_ceil = {1'b0, q_reg} + (MW+1)'(rem_reg != '0);

    always_comb
    begin
        if (elapsed_reg == '0)
        begin
            dterm_now = '0;
        end
        else if (dneg_reg)
        begin
            dterm_now = -$signed({1'b0, q_ceil});
        end
        else
        begin
            dterm_now = $signed({2'b00, q_reg});
        end
    end

    // Sum, floor to integer, saturate
    logic signed [SW-1:0] p_ext, p_shl, p_scaled, d_ext, sum, c_full;
    logic signed [CW-1:0] c, lim, c_sat, c_neg;

    assign p_ext    = pprod_reg;
    assign p_shl    = p_ext <<< F;
    assign p_scaled = p_shl >>> GAIN_W;
    assign d_ext    = dterm_reg;
    assign sum      = p_scaled + d_ext;
    assign c_full   = sum >>> F;
    assign c        = c_full[CW-1:0];
    assign lim      = $signed(CW'(cfg.max_correction));

    always_comb
    begin
        c_sat = c;
        if (c > lim)
        begin
            c_sat = lim;
        end
        if (c < -lim)
        begin
            c_sat = -lim;
        end
    end

    assign c_neg = -c_sat;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            raw_reg <= sensor_reading;
            ts_reg  <= timestamp_us;
        end
        if (cmd.prep)
        begin
            elapsed_reg <= elapsed_now;
            base_reg    <= refresh ? raw_reg : prev_sample_reg;
            v_reg       <= v_now;
            mid_reg     <= mid_sum[S:1];
        end
        if (cmd.mul)
        begin
            pprod_reg <= pprod_now;
            dmag_reg  <= dmag_now;
            dneg_reg  <= d_diff[DW-1];
        end
        if (cmd.div_load)
        begin
            q_reg   <= {dmag_reg, {F{1'b0}}};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= {q_reg[MW-2:0], div_ge};
            rem_reg <= rem_step;
        end
        if (cmd.fix)
        begin
            dterm_reg <= dterm_now;
        end
        if (cmd.finish)
        begin
            left_reg  <= c_sat[CORR_W-1:0];
            right_reg <= c_neg[CORR_W-1:0];
        end
    end

    // Stored sample/time and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            prev_time_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                prev_sample_reg <= v_reg;
                prev_time_reg   <= ts_reg;
                out_valid_reg   <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_blocked = out_valid_reg && out_stall;
    assign out_valid          = out_valid_reg;
    assign correction_left    = left_reg;
    assign correction_right   = right_reg;

endmodule

### rtl/core/line_follow_pd_controller.sv
// Top level of the line-follow PD controller: register file, sequencer and
// datapath. Depends on lfpd_pkg, lfpd_ctrl and lfpd_dp.
//
//   channel  | signals                                                  | direction
//   ---------+----------------------------------------------------------+-----------
//   input    | in_valid, in_stall, sensor_reading, timestamp_us         | in
//   output   | out_valid, out_stall, correction_left, correction_right  | out
//   config   | cfg_we, cfg_index, cfg_data                              | in
//
// A transaction passes from acceptance through prepare, multiply, divider load, the divider
// steps, fix and finish before the next acceptance; its length is set by the restoring
// divider of the D term, which makes one quotient bit per cycle over 16 + SAMPLE_BITS +
// FRAC_BITS bits. A new transaction is taken while the previous result still waits; the
// block only holds at its final step if that result has not been taken yet. Reset is
// asynchronous; no clearing pass is needed.

module line_follow_pd_controller
    import lfpd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [SAMPLE_BITS-1:0]   sensor_reading,
    input  logic [TIME_W-1:0]        timestamp_us,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [CORR_W-1:0] correction_left,
    output logic signed [CORR_W-1:0] correction_right,
    input  logic                     cfg_we,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int DIV_STEPS = GAIN_W + SAMPLE_BITS + FRAC_BITS;

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t status;

    // Register file; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_low       <= LINE_W'(0);
            cfg_reg.line_high      <= LINE_W'(1023);
            cfg_reg.stale_time_us  <= TIME_W'(100000);
            cfg_reg.p_gain_q16     <= GAIN_W'(9830);
            cfg_reg.d_gain         <= GAIN_W'(1000);
            cfg_reg.max_correction <= MAXC_W'(25);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINE_LOW:  cfg_reg.line_low       <= cfg_data[LINE_W-1:0];
                CFG_LINE_HIGH: cfg_reg.line_high      <= cfg_data[LINE_W-1:0];
                CFG_STALE:     cfg_reg.stale_time_us  <= cfg_data[TIME_W-1:0];
                CFG_P_GAIN:    cfg_reg.p_gain_q16     <= cfg_data[GAIN_W-1:0];
                CFG_D_GAIN:    cfg_reg.d_gain         <= cfg_data[GAIN_W-1:0];
                CFG_MAX_CORR:  cfg_reg.max_correction <= cfg_data[MAXC_W-1:0];
                default:       ;
            endcase
        end
    end

    lfpd_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lfpd_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .cmd              (cmd),
        .status           (status),
        .sensor_reading   (sensor_reading),
        .timestamp_us     (timestamp_us),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .correction_left  (correction_left),
        .correction_right (correction_right)
    );

endmodule

### rtl/core/lfpd_checker.sv
// Port-level checks of the line-follow PD controller and their bind.
// Depends on lfpd_pkg and line_follow_pd_controller.

module lfpd_checker
    import lfpd_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [CORR_W-1:0] correction_left,
    input logic signed [CORR_W-1:0] correction_right
);

    // A waiting result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(correction_left))
        else $error("stalled result changed or dropped");

    // The two wheels always get opposite corrections
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> correction_right == -correction_left)
        else $error("right correction is not the negation of left");

    // Saturation never yields the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> correction_left != 8'sh80)
        else $error("correction outside symmetric range");

    // After a transaction is taken the block is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again without processing");

endmodule

bind line_follow_pd_controller lfpd_checker u_lfpd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .correction_left  (correction_left),
    .correction_right (correction_right)
);
